[rtl/frt_pkg.sv]
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int MAX_BLOCKS_DEF = 32;

    localparam int SESSION_W = 16;
    localparam int COUNT_W   = 8;
    localparam int TOTAL_W   = 6;
    localparam int MASK_W    = 32;
    localparam int IDX_W     = 6;
    localparam int EXP_W     = 5;
    localparam int TTL_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int ADDR_W    = 9;

    localparam logic [TTL_W-1:0] TTL_RESET = 8'd2;

    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TICK      = 3'd4;

    localparam logic OP_BLOCK = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic                 op;
        logic [SESSION_W-1:0] session;
        logic [COUNT_W-1:0]   block_total;
        logic [COUNT_W-1:0]   block_index;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   store_address;
        logic [EXP_W-1:0]    expired_count;
    } out_word_t;

    // request token walking down the row of slot cells
    typedef struct packed {
        logic                 valid;
        logic                 op;
        logic [SESSION_W-1:0] session;
        logic [COUNT_W-1:0]   total;
        logic [COUNT_W-1:0]   index;
        logic                 found;
        logic [IDX_W-1:0]     match_idx;
        logic [TOTAL_W-1:0]   found_total;
        logic [MASK_W-1:0]    found_mask;
        logic                 spare;
        logic [IDX_W-1:0]     spare_idx;
        logic [EXP_W-1:0]     expired;
    } tok_t;

    // slot update broadcast from the controller
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic                 used;
        logic [SESSION_W-1:0] session;
        logic [TOTAL_W-1:0]   total;
        logic [MASK_W-1:0]    mask;
        logic [TTL_W-1:0]     ttl;
    } wr_t;

endpackage

[rtl/frt_cell.sv]
// ----------------------------------------------------------------------------
// frt_cell
// One session slot: holds its state, inspects the passing token and
// forwards it to the next cell through its token register.
// ----------------------------------------------------------------------------
module frt_cell
    import frt_pkg::*;
#(
    parameter int SLOT_ID = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok_in,
    input  wr_t  wr,
    output tok_t tok_out
);

    logic                 used_reg;
    logic                 used_next;
    logic [SESSION_W-1:0] session_reg;
    logic [SESSION_W-1:0] session_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [MASK_W-1:0]    mask_reg;
    logic [MASK_W-1:0]    mask_next;
    logic [TTL_W-1:0]     ttl_reg;
    logic [TTL_W-1:0]     ttl_next;
    tok_t                 tok_reg;
    tok_t                 tok_next;
    logic                 is_tick;
    logic                 is_block;

    assign is_tick  = tok_in.valid && (tok_in.op == OP_TICK);
    assign is_block = tok_in.valid && (tok_in.op == OP_BLOCK);

    always_comb
    begin
        tok_next     = tok_in;
        used_next    = used_reg;
        session_next = session_reg;
        total_next   = total_reg;
        mask_next    = mask_reg;
        ttl_next     = ttl_reg;
        if (is_block)
        begin
            if (used_reg && !tok_in.found && (session_reg == tok_in.session))
            begin
                tok_next.found       = 1'b1;
                tok_next.match_idx   = IDX_W'(SLOT_ID);
                tok_next.found_total = total_reg;
                tok_next.found_mask  = mask_reg;
            end
            if (!used_reg && !tok_in.spare)
            begin
                tok_next.spare     = 1'b1;
                tok_next.spare_idx = IDX_W'(SLOT_ID);
            end
        end
        if (is_tick && used_reg)
        begin
            if (ttl_reg == '0)
            begin
                used_next = 1'b0;
                if (tok_in.expired != '1)
                begin
                    tok_next.expired = tok_in.expired + EXP_W'(1);
                end
            end
            else
            begin
                ttl_next = ttl_reg - TTL_W'(1);
            end
        end
        else if (wr.en && (wr.idx == IDX_W'(SLOT_ID)))
        begin
            used_next    = wr.used;
            session_next = wr.session;
            total_next   = wr.total;
            mask_next    = wr.mask;
            ttl_next     = wr.ttl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        session_reg <= session_next;
        total_reg   <= total_next;
        mask_reg    <= mask_next;
        ttl_reg     <= ttl_next;
    end

    assign tok_out = tok_reg;

endmodule

[rtl/frt_ctrl.sv]
// ----------------------------------------------------------------------------
// frt_ctrl
// Launches tokens into the cell row, decides each item once its token has
// passed every slot, broadcasts the slot update and holds the result.
// ----------------------------------------------------------------------------
module frt_ctrl
    import frt_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [TTL_W-1:0] cfg_data,
    output tok_t      tok_first,
    input  tok_t      tok_last,
    output wr_t       wr
);

    localparam int MUL_W = 13;

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    tok_t             hold_reg;
    logic [TTL_W-1:0] ttl_reload_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_word_t        out_reg;
    out_word_t        out_next;
    logic             load;
    logic             malformed;
    logic [IDX_W-1:0] tgt;
    logic [TOTAL_W-1:0] tot;
    logic [MASK_W-1:0]  new_mask;
    logic [MASK_W:0]    full;
    logic               complete;
    logic [MUL_W-1:0]   addr;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        tok_first             = '0;
        tok_first.valid       = in_valid && in_ready;
        tok_first.op          = in_word.op;
        tok_first.session     = in_word.session;
        tok_first.total       = in_word.block_total;
        tok_first.index       = in_word.block_index;
    end

    assign malformed = (hold_reg.session == '0) || (hold_reg.total == '0)
                    || (hold_reg.total > COUNT_W'(MAX_BLOCKS))
                    || (hold_reg.index >= hold_reg.total);
    assign tgt       = hold_reg.found ? hold_reg.match_idx : hold_reg.spare_idx;
    assign tot       = hold_reg.found ? hold_reg.found_total
                                      : hold_reg.total[TOTAL_W-1:0];
    assign new_mask  = (hold_reg.found ? hold_reg.found_mask : '0)
                     | (MASK_W'(1) << hold_reg.index[4:0]);
    assign full      = ({{MASK_W{1'b0}}, 1'b1} << tot) - (MASK_W+1)'(1);
    assign complete  = (new_mask == full[MASK_W-1:0]);
    assign addr      = MUL_W'(tgt) * MUL_W'(MAX_BLOCKS) + MUL_W'(hold_reg.index);

    always_comb
    begin
        state_next     = state_reg;
        load           = 1'b0;
        out_next       = out_reg;
        wr             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (tok_last.valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    out_next   = '0;
                    if (hold_reg.op == OP_TICK)
                    begin
                        out_next.status        = ST_TICK;
                        out_next.expired_count = hold_reg.expired;
                    end
                    else if (malformed)
                    begin
                        out_next.status = ST_MALFORMED;
                    end
                    else if (!hold_reg.found && !hold_reg.spare)
                    begin
                        out_next.status = ST_FULL;
                    end
                    else if (hold_reg.found
                             && (hold_reg.index >= COUNT_W'(hold_reg.found_total)))
                    begin
                        out_next.status = ST_MALFORMED;
                    end
                    else
                    begin
                        out_next.status        = complete ? ST_COMPLETE : ST_STORED;
                        out_next.slot          = tgt[SLOT_W-1:0];
                        out_next.store_address = addr[ADDR_W-1:0];
                        wr.en      = 1'b1;
                        wr.idx     = tgt;
                        wr.used    = !complete;
                        wr.session = hold_reg.session;
                        wr.total   = tot;
                        wr.mask    = complete ? '0 : new_mask;
                        wr.ttl     = ttl_reload_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            ttl_reload_reg <= TTL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ttl_reload_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if ((state_reg == S_RUN) && tok_last.valid)
        begin
            hold_reg <= tok_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

[rtl/fragment_reassembly_tracker_unit.sv]
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_unit
// Session slot table for multi-block message reassembly.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready, in_word) are either a block arrival or an
// aging tick; each gives exactly one result word on out_valid/out_ready.
// cfg_valid/cfg_data writes ttl_reload; cfg_ready is always high.
// One word is in flight at a time. Its token walks the row of SLOTS slot
// cells, one cell per cycle, collecting the matching slot, the first free
// slot and the expiry count; a last step decides and updates the slot.
// in_ready is high again once the result sits in the output register, so
// the next word starts while it waits.
// If the receiver stalls, the finished token is held before the decision
// and no further word is taken until the output register is free.
// Reset frees every slot, clears the output and sets ttl_reload to 2.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_unit
    import frt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_word,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TTL_W-1:0] cfg_data
);

    tok_t tok_chain [SLOTS+1];
    wr_t  wr;

    frt_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .tok_first (tok_chain[0]),
        .tok_last  (tok_chain[SLOTS]),
        .wr        (wr)
    );

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        frt_cell #(
            .SLOT_ID (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[i]),
            .wr      (wr),
            .tok_out (tok_chain[i+1])
        );
    end

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while one is in flight");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared with no word in flight");

    a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.status == ST_TICK))
            |-> ((out_word.slot == '0) && (out_word.store_address == '0)))
        else $error("tick result carries a slot or address");

    a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_word.status == ST_FULL) || (out_word.status == ST_MALFORMED)))
            |-> ((out_word.slot == '0) && (out_word.expired_count == '0)))
        else $error("dropped block result carries a slot or count");
`endif

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fragment reassembly tracker unit.
// Block and tick words are queued by phase; most phases add random gaps. Each
// accepted word is run through a slot-table predictor. Every result from the
// unit is checked field by field against the oldest prediction. The
// time-to-live reload is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
    import frt_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int MAX_BLOCKS     = MAX_BLOCKS_DEF;
    localparam int GAP_MAX        = 17;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 10;
    localparam int PHASE_WORDS    = 105;
    localparam int MSG_MAX        = 24;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_word_t         in_word   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_word_t        out_word;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TTL_W-1:0] cfg_data  = '0;

    fragment_reassembly_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predicted slot table
    logic                 tbl_used    [SLOTS];
    logic [SESSION_W-1:0] tbl_session [SLOTS];
    logic [TOTAL_W-1:0]   tbl_total   [SLOTS];
    logic [MASK_W-1:0]    tbl_mask    [SLOTS];
    logic [TTL_W-1:0]     tbl_ttl     [SLOTS];
    logic [TTL_W-1:0]     ttl_setting = TTL_RESET;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    out_word_t want_word;

    // open messages of the stimulus generator
    logic [SESSION_W-1:0] msg_session [MSG_MAX];
    int                   msg_total   [MSG_MAX];
    logic [MASK_W-1:0]    msg_sent    [MSG_MAX];

    int   gap_left     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   holds_req    = 0;
    int   holds_served = 0;
    bit   gaps_on      = 1'b1;
    bit   stalls_on    = 1'b1;
    int   quiet_cycles = 0;
    int   mismatches   = 0;
    int   words_sent   = 0;
    int   ticks_sent   = 0;
    int   results_seen = 0;
    int   ttl_writes   = 0;
    int   seen_status [8];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i]    = 1'b0;
            tbl_session[i] = '0;
            tbl_total[i]   = '0;
            tbl_mask[i]    = '0;
            tbl_ttl[i]     = '0;
        end
        for (int i = 0; i < 8; i++) seen_status[i] = 0;
    end

    function automatic out_word_t reassembly_outcome(input in_word_t w);
        out_word_t   r;
        int          hit;
        int          free_slot;
        int          freed;
        logic [63:0] full;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        freed     = 0;
        if (w.op == OP_TICK) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_used[i]) begin
                    if (tbl_ttl[i] == 0) begin
                        tbl_used[i] = 1'b0;
                        freed++;
                    end
                    else begin
                        tbl_ttl[i] = tbl_ttl[i] - 1'b1;
                    end
                end
            end
            r.status        = ST_TICK;
            r.expired_count = (freed > 31) ? 5'd31 : freed[EXP_W-1:0];
            return r;
        end
        if (w.session == 0 || w.block_total == 0 || w.block_total > MAX_BLOCKS
            || w.block_index >= w.block_total) begin
            r.status = ST_MALFORMED;
            return r;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0) begin
                if (tbl_used[i] && tbl_session[i] == w.session)
                    hit = i;
                else if (free_slot < 0 && !tbl_used[i])
                    free_slot = i;
            end
        end
        if (hit < 0 && free_slot < 0) begin
            r.status = ST_FULL;
            return r;
        end
        if (hit < 0) begin
            hit              = free_slot;
            tbl_used[hit]    = 1'b1;
            tbl_session[hit] = w.session;
            tbl_total[hit]   = w.block_total[TOTAL_W-1:0];
            tbl_mask[hit]    = '0;
        end
        else if (w.block_index >= tbl_total[hit]) begin
            r.status = ST_MALFORMED;
            return r;
        end
        tbl_mask[hit][w.block_index[4:0]] = 1'b1;
        tbl_ttl[hit]    = ttl_setting;
        full            = (64'd1 << tbl_total[hit]) - 64'd1;
        r.slot          = hit[SLOT_W-1:0];
        r.store_address = ADDR_W'(hit * MAX_BLOCKS + w.block_index);
        if ({32'd0, tbl_mask[hit]} == full) begin
            tbl_used[hit] = 1'b0;
            tbl_mask[hit] = '0;
            r.status      = ST_COMPLETE;
        end
        else begin
            r.status = ST_STORED;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic push_block(input int s, input int t, input int idx);
        in_word_t w;
        w.op          = OP_BLOCK;
        w.session     = s[SESSION_W-1:0];
        w.block_total = t[COUNT_W-1:0];
        w.block_index = idx[COUNT_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic push_tick();
        in_word_t w;
        w.op          = OP_TICK;
        w.session     = SESSION_W'($urandom);
        w.block_total = COUNT_W'($urandom);
        w.block_index = COUNT_W'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic drain_all();
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_ttl(input logic [TTL_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ttl_writes++;
        @(negedge clk);
    endtask

    task automatic open_message(input int k);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            msg_session[k] = 16'hFFFF;
        else if (r == 1)
            msg_session[k] = SESSION_W'($urandom_range(1, 8));
        else
            msg_session[k] = SESSION_W'($urandom_range(1, 65535));
        r = $urandom_range(0, 9);
        if (r == 0)
            msg_total[k] = MAX_BLOCKS;
        else if (r == 1)
            msg_total[k] = $urandom_range(1, MAX_BLOCKS);
        else
            msg_total[k] = $urandom_range(1, 6);
        msg_sent[k] = '0;
    endtask

    task automatic queue_phase(input int n, input int conc);
        int          r;
        int          k;
        int          idx;
        logic [63:0] all_sent;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, conc - 1);
            if (r < 8) begin
                push_tick();
            end
            else if (r < 14) begin
                push_block(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535),
                           $urandom_range(0, 255), $urandom_range(0, 255));
            end
            else if (r < 18 && msg_total[k] < MAX_BLOCKS) begin
                // claims a larger count than the slot was opened with
                push_block(msg_session[k], MAX_BLOCKS,
                           $urandom_range(msg_total[k], MAX_BLOCKS - 1));
            end
            else if (r < 22) begin
                push_block(msg_session[k], msg_total[k], $urandom_range(0, msg_total[k] - 1));
            end
            else begin
                do idx = $urandom_range(0, msg_total[k] - 1); while (msg_sent[k][idx]);
                msg_sent[k][idx] = 1'b1;
                push_block(msg_session[k], msg_total[k], idx);
                all_sent = (64'd1 << msg_total[k]) - 64'd1;
                if ({32'd0, msg_sent[k]} == all_sent)
                    open_message(k);
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                ttl_setting = cfg_data;
            if (in_valid && in_ready) begin
                expected_words.push_back(reassembly_outcome(in_word));
                words_sent++;
                if (in_word.op == OP_TICK)
                    ticks_sent++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_words.size() != 0) begin
                    in_valid <= 1'b1;
                    in_word  <= pending_words.pop_front();
                    gap_left <= gaps_on ? $urandom_range(0, GAP_MAX) : 0;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left = 0;
            hold_left  <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, status", out_word.status, 0);
                end
                else begin
                    want_word = expected_words.pop_front();
                    if (out_word.status !== want_word.status)
                        report_mismatch("status", out_word.status, want_word.status);
                    if (out_word.slot !== want_word.slot)
                        report_mismatch("slot", out_word.slot, want_word.slot);
                    if (out_word.store_address !== want_word.store_address)
                        report_mismatch("store_address", out_word.store_address,
                                        want_word.store_address);
                    if (out_word.expired_count !== want_word.expired_count)
                        report_mismatch("expired_count", out_word.expired_count,
                                        want_word.expired_count);
                end
                seen_status[out_word.status]++;
                results_seen++;
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (holds_served != holds_req) begin
                hold_left    <= HOLD_CYCLES;
                holds_served <= holds_served + 1;
                out_ready    <= 1'b0;
            end
            else if (out_valid && out_ready) begin
                stall_left = stalls_on ? $urandom_range(0, GAP_MAX) : 0;
                out_ready  <= (stall_left == 0);
                if (stall_left != 0)
                    stall_left = stall_left - 1;
            end
            else if (stall_left != 0) begin
                stall_left = stall_left - 1;
                out_ready  <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("[fragment_reassembly_tracker_unit] ERROR");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ttl_pick;
        int conc;
        bit hold;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // malformed words, then count mismatch and index beyond the stored count
        push_block(0, 4, 0);
        push_block(5, 0, 0);
        push_block(5, MAX_BLOCKS + 1, 0);
        push_block(16'hFFFF, 255, 255);
        push_block(5, 4, 4);
        push_block(16'hFFFF, MAX_BLOCKS, MAX_BLOCKS - 1);
        push_block(16'hFFFF, 1, 0);
        push_block(7, 2, 0);
        push_block(7, 8, 5);
        push_block(7, 2, 0);
        push_block(7, 2, 1);
        push_block(1, 1, 0);
        push_tick();
        push_tick();
        push_tick();
        drain_all();

        // zero reload: slot is freed on the very next tick
        write_ttl(8'd0);
        push_block(9, 3, 0);
        push_tick();
        push_block(9, 3, 1);
        drain_all();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 5)
                0:       ttl_pick = 255;
                1:       ttl_pick = 0;
                2:       ttl_pick = $urandom_range(1, 3);
                3:       ttl_pick = 2;
                default: ttl_pick = $urandom_range(0, 255);
            endcase
            write_ttl(TTL_W'(ttl_pick));
            hold      = (p == 2 || p == 7);
            gaps_on   = (p % 3 != 1) && !hold;
            stalls_on = (p % 4 != 3);
            conc      = (p % 5 == 0) ? MSG_MAX : $urandom_range(1, 20);
            for (int k = 0; k < MSG_MAX; k++)
                open_message(k);
            if (hold)
                holds_req++;
            queue_phase(PHASE_WORDS, conc);
            drain_all();
        end

        repeat (SLOTS + 4) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("results never seen", 0, expected_words.size());
        $display("covered %0d words (%0d ticks), %0d results, %0d reload writes, %0d holds",
                 words_sent, ticks_sent, results_seen, ttl_writes, holds_served);
        $display("stored %0d, complete %0d, table full %0d, malformed %0d, tick %0d",
                 seen_status[ST_STORED], seen_status[ST_COMPLETE], seen_status[ST_FULL],
                 seen_status[ST_MALFORMED], seen_status[ST_TICK]);
        if (mismatches == 0)
            $display("[fragment_reassembly_tracker_unit] OK");
        else
            $display("[fragment_reassembly_tracker_unit] ERROR");
        $finish;
    end

endmodule

[fragment_reassembly_tracker_unit.f]
rtl/frt_pkg.sv
rtl/frt_cell.sv
rtl/frt_ctrl.sv
rtl/fragment_reassembly_tracker_unit.sv
test/tb.sv
